// ===== rtl/sli_pkg.sv =====
package sli_pkg;

   localparam int StackDepth = 1024;
   localparam int StackAw    = $clog2(StackDepth);
   localparam int StackCw    = StackAw + 1;
   localparam int NumVars    = 26;
   localparam int VarAw      = 5;

   typedef logic [31:0] word_type;

   // divider request and response
   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quotient;
      word_type remainder;
   } div_rsp_type;

   // result kinds
   localparam logic [1:0] KIND_NUM    = 2'd0;
   localparam logic [1:0] KIND_CHAR   = 2'd1;
   localparam logic [1:0] KIND_RESULT = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
   localparam logic [2:0] ERR_BAD_CHAR  = 3'd3;
   localparam logic [2:0] ERR_BAD_ADDR  = 3'd4;
   localparam logic [2:0] ERR_DIV_ZERO  = 3'd5;

   // lexer states
   localparam logic [2:0] LX_IDLE    = 3'd0;
   localparam logic [2:0] LX_NUMBER  = 3'd1;
   localparam logic [2:0] LX_CHARLIT = 3'd2;
   localparam logic [2:0] LX_READ    = 3'd3;
   localparam logic [2:0] LX_PRINT   = 3'd4;
   localparam logic [2:0] LX_STRING  = 3'd5;
   localparam logic [2:0] LX_HALTED  = 3'd6;

   // stack operations
   localparam logic [3:0] OP_FINAL = 4'd0;
   localparam logic [3:0] OP_PRINT = 4'd1;
   localparam logic [3:0] OP_FETCH = 4'd2;
   localparam logic [3:0] OP_STORE = 4'd3;
   localparam logic [3:0] OP_ADD   = 4'd4;
   localparam logic [3:0] OP_SUB   = 4'd5;
   localparam logic [3:0] OP_MUL   = 4'd6;
   localparam logic [3:0] OP_DIV   = 4'd7;
   localparam logic [3:0] OP_MOD   = 4'd8;
   localparam logic [3:0] OP_LT    = 4'd9;
   localparam logic [3:0] OP_EQ    = 4'd10;
   localparam logic [3:0] OP_GT    = 4'd11;

   // follow-up work after a pending push or print
   localparam logic [1:0] NX_NONE  = 2'd0;
   localparam logic [1:0] NX_CHAR  = 2'd1;
   localparam logic [1:0] NX_FINAL = 2'd2;

   // characters of the language
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_TICK   = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GREAT  = 8'h3E;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_UPPA   = 8'h41;
   localparam logic [7:0] CH_UPPZ   = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

// ===== rtl/stack_language_interpreter_unit.sv =====
// A character that only moves the lexer needs no stack access; a stack operation reads its
// operands from the stack, and / or \ also waits for the shared 32-step divider.
// A pending number or read is pushed first; each result is then drained in turn.
// Throughput: one transaction at a time; the next is taken after all results are drained.
// Reset (synchronous, active high): empty stack, variables and accumulator zero,
// lexer idle. Stack memory contents are not cleared; only entries below the count are read.
module stack_language_interpreter_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [7:0]         req_code_char,
   input  logic signed [31:0] req_read_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_last
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_PUSH   = 4'd2;
   localparam logic [3:0] S_NEXT   = 4'd3;
   localparam logic [3:0] S_IC     = 4'd4;
   localparam logic [3:0] S_RDB    = 4'd5;
   localparam logic [3:0] S_RDA    = 4'd6;
   localparam logic [3:0] S_RDA2   = 4'd7;
   localparam logic [3:0] S_EXEC   = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0]                  state_ff, state_in;
   logic                        mode_ff, mode_in;
   logic [7:0]                  ch_ff, ch_in;
   logic [31:0]                 rv_ff, rv_in;
   logic [sli_pkg::StackCw-1:0] cnt_ff, cnt_in;
   logic [31:0]                 acc_ff, acc_in;
   logic [2:0]                  lex_ff, lex_in;
   logic [31:0]                 var_ff [sli_pkg::NumVars];
   logic [31:0]                 var_in [sli_pkg::NumVars];
   logic [3:0]                  op_ff, op_in;
   logic [1:0]                  next_ff, next_in;
   logic [31:0]                 pv_ff, pv_in;
   logic [31:0]                 opa_ff, opa_in;
   logic [31:0]                 opb_ff, opb_in;

   logic [1:0]                  res_kind_ff [2];
   logic [31:0]                 res_val_ff  [2];
   logic [2:0]                  res_err_ff  [2];
   logic                        res_last_ff [2];
   logic [1:0]                  res_n_ff;
   logic                        head_ff;

   logic [31:0]                 mem [sli_pkg::StackDepth];
   logic [31:0]                 rd_data_ff;
   logic [sli_pkg::StackCw-1:0] rd_cnt;
   logic                        wr_en;

   logic                        emit_en;
   logic [1:0]                  emit_kind;
   logic [31:0]                 emit_val;
   logic [2:0]                  emit_err;
   logic                        two_op;
   logic                        is_digit;
   logic [7:0]                  digit;
   logic [31:0]                 prod;
   logic                        rsp_take;

   sli_pkg::div_req_type        div_req;
   sli_pkg::div_rsp_type        div_rsp;

   sli_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_take  = (state_ff == S_OUT) && !rsp_stall;
   assign is_digit  = (ch_ff >= sli_pkg::CH_ZERO) && (ch_ff <= sli_pkg::CH_NINE);
   assign digit     = ch_ff - sli_pkg::CH_ZERO;
   assign two_op    = (op_ff != sli_pkg::OP_FINAL) && (op_ff != sli_pkg::OP_PRINT)
                      && (op_ff != sli_pkg::OP_FETCH);
   assign prod      = opa_ff * opb_ff;

   // sequence one transaction through decode, stack access and the shared units
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      ch_in     = ch_ff;
      rv_in     = rv_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      lex_in    = lex_ff;
      var_in    = var_ff;
      op_in     = op_ff;
      next_in   = next_ff;
      pv_in     = pv_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      emit_en   = 1'b0;
      emit_kind = sli_pkg::KIND_NUM;
      emit_val  = '0;
      emit_err  = sli_pkg::ERR_NONE;
      wr_en     = 1'b0;
      rd_cnt    = cnt_ff - sli_pkg::StackCw'(1);
      div_req.start    = 1'b0;
      div_req.dividend = opa_ff;
      div_req.divisor  = opb_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               ch_in    = req_code_char;
               rv_in    = req_read_value;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            if (mode_ff) begin
               next_in = sli_pkg::NX_FINAL;
               case (lex_ff)
                  sli_pkg::LX_NUMBER: begin
                     lex_in   = sli_pkg::LX_IDLE;
                     pv_in    = acc_ff;
                     state_in = S_PUSH;
                  end
                  sli_pkg::LX_READ: begin
                     lex_in   = sli_pkg::LX_IDLE;
                     pv_in    = rv_ff;
                     state_in = S_PUSH;
                  end
                  sli_pkg::LX_PRINT: begin
                     lex_in    = sli_pkg::LX_IDLE;
                     emit_en   = 1'b1;
                     emit_kind = sli_pkg::KIND_NUM;
                     emit_val  = acc_ff;
                     state_in  = S_NEXT;
                  end
                  sli_pkg::LX_HALTED: begin
                     state_in = S_DONE;
                  end
                  default: begin
                     lex_in   = sli_pkg::LX_IDLE;
                     state_in = S_NEXT;
                  end
               endcase
            end else begin
               case (lex_ff)
                  sli_pkg::LX_HALTED: begin
                     state_in = S_DONE;
                  end
                  sli_pkg::LX_NUMBER: begin
                     if (is_digit) begin
                        acc_in   = (acc_ff << 3) + (acc_ff << 1) + {24'd0, digit};
                        state_in = S_DONE;
                     end else begin
                        lex_in   = sli_pkg::LX_IDLE;
                        pv_in    = acc_ff;
                        next_in  = sli_pkg::NX_CHAR;
                        state_in = S_PUSH;
                     end
                  end
                  sli_pkg::LX_CHARLIT: begin
                     lex_in   = sli_pkg::LX_IDLE;
                     pv_in    = {24'd0, ch_ff};
                     next_in  = sli_pkg::NX_NONE;
                     state_in = S_PUSH;
                  end
                  sli_pkg::LX_READ: begin
                     lex_in   = sli_pkg::LX_IDLE;
                     pv_in    = rv_ff;
                     next_in  = (ch_ff == sli_pkg::CH_TICK) ? sli_pkg::NX_NONE
                                                            : sli_pkg::NX_CHAR;
                     state_in = S_PUSH;
                  end
                  sli_pkg::LX_PRINT: begin
                     lex_in  = sli_pkg::LX_IDLE;
                     emit_en = 1'b1;
                     if (ch_ff == sli_pkg::CH_TICK) begin
                        emit_kind = sli_pkg::KIND_CHAR;
                        emit_val  = {24'd0, acc_ff[7:0]};
                        state_in  = S_DONE;
                     end else begin
                        emit_kind = sli_pkg::KIND_NUM;
                        emit_val  = acc_ff;
                        next_in   = sli_pkg::NX_CHAR;
                        state_in  = S_NEXT;
                     end
                  end
                  sli_pkg::LX_STRING: begin
                     if (ch_ff == sli_pkg::CH_QUOTE) begin
                        lex_in = sli_pkg::LX_IDLE;
                     end else begin
                        emit_en   = 1'b1;
                        emit_kind = sli_pkg::KIND_CHAR;
                        emit_val  = (ch_ff == sli_pkg::CH_BANG) ? {24'd0, sli_pkg::CH_LF}
                                                                : {24'd0, ch_ff};
                     end
                     state_in = S_DONE;
                  end
                  default: begin
                     lex_in   = sli_pkg::LX_IDLE;
                     state_in = S_IC;
                  end
               endcase
            end
         end

         S_PUSH: begin
            if (cnt_ff >= sli_pkg::StackCw'(sli_pkg::StackDepth)) begin
               emit_en   = 1'b1;
               emit_kind = sli_pkg::KIND_ERROR;
               emit_err  = sli_pkg::ERR_OVERFLOW;
               lex_in    = sli_pkg::LX_HALTED;
               state_in  = S_DONE;
            end else begin
               wr_en    = 1'b1;
               cnt_in   = cnt_ff + sli_pkg::StackCw'(1);
               state_in = S_NEXT;
            end
         end

         S_NEXT: begin
            if (lex_ff == sli_pkg::LX_HALTED || next_ff == sli_pkg::NX_NONE) begin
               state_in = S_DONE;
            end else if (next_ff == sli_pkg::NX_FINAL) begin
               op_in = sli_pkg::OP_FINAL;
               if (cnt_ff == '0) begin
                  emit_en   = 1'b1;
                  emit_kind = sli_pkg::KIND_ERROR;
                  emit_err  = sli_pkg::ERR_UNDERFLOW;
                  lex_in    = sli_pkg::LX_HALTED;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_RDB;
               end
            end else begin
               state_in = S_IC;
            end
         end

         S_IC: begin
            next_in  = sli_pkg::NX_NONE;
            state_in = S_DONE;
            if (ch_ff == sli_pkg::CH_SPACE || ch_ff == sli_pkg::CH_TAB ||
                ch_ff == sli_pkg::CH_LF || ch_ff == sli_pkg::CH_CR) begin
               state_in = S_DONE;
            end else if (is_digit) begin
               acc_in = {24'd0, digit};
               lex_in = sli_pkg::LX_NUMBER;
            end else if (ch_ff >= sli_pkg::CH_UPPA && ch_ff <= sli_pkg::CH_UPPZ) begin
               pv_in    = {24'd0, ch_ff - sli_pkg::CH_UPPA};
               state_in = S_PUSH;
            end else if (ch_ff == sli_pkg::CH_TICK) begin
               lex_in = sli_pkg::LX_CHARLIT;
            end else if (ch_ff == sli_pkg::CH_QMARK) begin
               lex_in = sli_pkg::LX_READ;
            end else if (ch_ff == sli_pkg::CH_QUOTE) begin
               lex_in = sli_pkg::LX_STRING;
            end else if (ch_ff == sli_pkg::CH_BANG || ch_ff == sli_pkg::CH_DOLLAR ||
                         ch_ff == sli_pkg::CH_DOT) begin
               // single-operand forms
               if (ch_ff == sli_pkg::CH_BANG) begin
                  op_in = sli_pkg::OP_PRINT;
               end else if (ch_ff == sli_pkg::CH_DOLLAR) begin
                  op_in = sli_pkg::OP_FINAL;
               end else begin
                  op_in = sli_pkg::OP_FETCH;
               end
               if (cnt_ff == '0) begin
                  emit_en   = 1'b1;
                  emit_kind = sli_pkg::KIND_ERROR;
                  emit_err  = sli_pkg::ERR_UNDERFLOW;
                  lex_in    = sli_pkg::LX_HALTED;
               end else begin
                  state_in = S_RDB;
               end
            end else if (ch_ff == sli_pkg::CH_COLON || ch_ff == sli_pkg::CH_PLUS ||
                         ch_ff == sli_pkg::CH_MINUS || ch_ff == sli_pkg::CH_STAR ||
                         ch_ff == sli_pkg::CH_SLASH || ch_ff == sli_pkg::CH_BSLASH ||
                         ch_ff == sli_pkg::CH_LESS || ch_ff == sli_pkg::CH_EQUAL ||
                         ch_ff == sli_pkg::CH_GREAT) begin
               // two-operand forms
               case (ch_ff)
                  sli_pkg::CH_COLON:  op_in = sli_pkg::OP_STORE;
                  sli_pkg::CH_PLUS:   op_in = sli_pkg::OP_ADD;
                  sli_pkg::CH_MINUS:  op_in = sli_pkg::OP_SUB;
                  sli_pkg::CH_STAR:   op_in = sli_pkg::OP_MUL;
                  sli_pkg::CH_SLASH:  op_in = sli_pkg::OP_DIV;
                  sli_pkg::CH_BSLASH: op_in = sli_pkg::OP_MOD;
                  sli_pkg::CH_LESS:   op_in = sli_pkg::OP_LT;
                  sli_pkg::CH_EQUAL:  op_in = sli_pkg::OP_EQ;
                  default:            op_in = sli_pkg::OP_GT;
               endcase
               if (cnt_ff < sli_pkg::StackCw'(2)) begin
                  emit_en   = 1'b1;
                  emit_kind = sli_pkg::KIND_ERROR;
                  emit_err  = sli_pkg::ERR_UNDERFLOW;
                  lex_in    = sli_pkg::LX_HALTED;
               end else begin
                  state_in = S_RDB;
               end
            end else begin
               emit_en   = 1'b1;
               emit_kind = sli_pkg::KIND_ERROR;
               emit_err  = sli_pkg::ERR_BAD_CHAR;
               lex_in    = sli_pkg::LX_HALTED;
            end
         end

         S_RDB: begin
            state_in = S_RDA;
         end

         S_RDA: begin
            opb_in   = rd_data_ff;
            rd_cnt   = cnt_ff - sli_pkg::StackCw'(2);
            state_in = two_op ? S_RDA2 : S_EXEC;
         end

         S_RDA2: begin
            opa_in   = rd_data_ff;
            state_in = S_EXEC;
         end

         S_EXEC: begin
            next_in  = sli_pkg::NX_NONE;
            state_in = S_PUSH;
            cnt_in   = two_op ? cnt_ff - sli_pkg::StackCw'(2)
                              : cnt_ff - sli_pkg::StackCw'(1);
            case (op_ff)
               sli_pkg::OP_FINAL: begin
                  emit_en   = 1'b1;
                  emit_kind = sli_pkg::KIND_RESULT;
                  emit_val  = opb_ff;
                  lex_in    = sli_pkg::LX_HALTED;
                  state_in  = S_DONE;
               end
               sli_pkg::OP_PRINT: begin
                  acc_in   = opb_ff;
                  lex_in   = sli_pkg::LX_PRINT;
                  state_in = S_DONE;
               end
               sli_pkg::OP_FETCH, sli_pkg::OP_STORE: begin
                  if (opb_ff >= 32'(sli_pkg::NumVars)) begin
                     emit_en   = 1'b1;
                     emit_kind = sli_pkg::KIND_ERROR;
                     emit_err  = sli_pkg::ERR_BAD_ADDR;
                     lex_in    = sli_pkg::LX_HALTED;
                     state_in  = S_DONE;
                  end else if (op_ff == sli_pkg::OP_FETCH) begin
                     pv_in = var_ff[opb_ff[sli_pkg::VarAw-1:0]];
                  end else begin
                     var_in[opb_ff[sli_pkg::VarAw-1:0]] = opa_ff;
                     state_in = S_DONE;
                  end
               end
               sli_pkg::OP_ADD: pv_in = opa_ff + opb_ff;
               sli_pkg::OP_SUB: pv_in = opa_ff - opb_ff;
               sli_pkg::OP_MUL: pv_in = prod;
               sli_pkg::OP_LT:  pv_in = {31'd0, $signed(opa_ff) < $signed(opb_ff)};
               sli_pkg::OP_EQ:  pv_in = {31'd0, opa_ff == opb_ff};
               sli_pkg::OP_GT:  pv_in = {31'd0, $signed(opa_ff) > $signed(opb_ff)};
               default: begin
                  // divide or modulo
                  if (opb_ff == '0) begin
                     emit_en   = 1'b1;
                     emit_kind = sli_pkg::KIND_ERROR;
                     emit_err  = sli_pkg::ERR_DIV_ZERO;
                     lex_in    = sli_pkg::LX_HALTED;
                     state_in  = S_DONE;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
            endcase
         end

         S_DIV: begin
            if (div_rsp.done) begin
               pv_in    = (op_ff == sli_pkg::OP_DIV) ? div_rsp.quotient
                                                     : div_rsp.remainder;
               next_in  = sli_pkg::NX_NONE;
               state_in = S_PUSH;
            end
         end

         S_DONE: begin
            if (mode_ff) begin
               cnt_in = '0;
               acc_in = '0;
               lex_in = sli_pkg::LX_IDLE;
               for (int i = 0; i < sli_pkg::NumVars; i++) begin
                  var_in[i] = '0;
               end
            end
            state_in = (res_n_ff != 2'd0) ? S_OUT : S_IDLE;
         end

         S_OUT: begin
            if (rsp_take && (head_ff == res_n_ff[0] - 1'b1 || res_n_ff == 2'd1)) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[sli_pkg::StackAw-1:0]] <= pv_ff;
      end
      rd_data_ff <= mem[rd_cnt[sli_pkg::StackAw-1:0]];
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         lex_ff   <= sli_pkg::LX_IDLE;
         for (int i = 0; i < sli_pkg::NumVars; i++) begin
            var_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         lex_ff   <= lex_in;
         var_ff   <= var_in;
      end
      mode_ff <= mode_in;
      ch_ff   <= ch_in;
      rv_ff   <= rv_in;
      op_ff   <= op_in;
      next_ff <= next_in;
      pv_ff   <= pv_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
   end

   // result buffer: collect up to two results, mark the last, then drain
   always_ff @(posedge clock) begin
      if (reset) begin
         res_n_ff <= '0;
         head_ff  <= 1'b0;
      end else begin
         if (emit_en && res_n_ff != 2'd2) begin
            res_n_ff <= res_n_ff + 2'd1;
         end
         if (rsp_take) begin
            if (state_in == S_IDLE) begin
               res_n_ff <= '0;
               head_ff  <= 1'b0;
            end else begin
               head_ff <= 1'b1;
            end
         end
      end
      if (emit_en && res_n_ff != 2'd2) begin
         res_kind_ff[res_n_ff[0]] <= emit_kind;
         res_val_ff[res_n_ff[0]]  <= emit_val;
         res_err_ff[res_n_ff[0]]  <= emit_err;
         res_last_ff[res_n_ff[0]] <= 1'b0;
      end
      if (state_ff == S_DONE && res_n_ff != 2'd0) begin
         res_last_ff[res_n_ff[0] - 1'b1] <= 1'b1;
      end
   end

   assign rsp_valid      = (state_ff == S_OUT);
   assign rsp_kind       = res_kind_ff[head_ff];
   assign rsp_value      = res_val_ff[head_ff];
   assign rsp_error_code = res_err_ff[head_ff];
   assign rsp_last       = res_last_ff[head_ff];

   // stack count never passes the depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= sli_pkg::StackCw'(sli_pkg::StackDepth))
      else $error("stack count beyond depth");

   // an end transaction leaves an empty stack and an idle lexer
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && mode_ff) |=> (cnt_ff == '0 && lex_ff == sli_pkg::LX_IDLE))
      else $error("end transaction did not clear state");

   // a divider result is consumed only while waiting for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");

   // results are shown only when some were collected
   a_out_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> res_n_ff != 2'd0)
      else $error("result shown from an empty buffer");

endmodule

// ===== rtl/sli_divider.sv =====
module sli_divider (
   input  logic                clock,
   input  logic                reset,
   input  sli_pkg::div_req_type req,
   output sli_pkg::div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        negq_ff, negq_in;
   logic        negr_ff, negr_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   // one restoring step per cycle on magnitudes
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = req.dividend[31] ? -req.dividend : req.dividend;
         den_in  = req.divisor[31] ? -req.divisor : req.divisor;
         negq_in = req.dividend[31] ^ req.divisor[31];
         negr_in = req.dividend[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
   end

   // apply signs: quotient truncates toward zero, remainder follows dividend
   assign rsp.done      = done_ff;
   assign rsp.quotient  = negq_ff ? -quo_ff : quo_ff;
   assign rsp.remainder = negr_ff ? -rem_ff : rem_ff;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

import sli_pkg::*;

typedef struct {
   logic [1:0]  kind;
   logic [31:0] value;
   logic [2:0]  err;
   logic        last;
} interp_out_type;

class interp_scoreboard;
   logic [31:0]    stk [StackDepth];
   int unsigned    depth;
   logic [31:0]    vars [NumVars];
   logic [31:0]    acc;
   logic [2:0]     lex;
   interp_out_type item_outs [$];
   interp_out_type pending_outs [$];
   int             failures;

   function new();
      clear();
      failures = 0;
   endfunction

   function void clear();
      depth = 0;
      acc = '0;
      lex = LX_IDLE;
      foreach (vars[i]) vars[i] = '0;
   endfunction

   function void emit(logic [1:0] k, logic [31:0] v, logic [2:0] e);
      interp_out_type o;
      if (item_outs.size() >= 2) return;
      o.kind = k; o.value = v; o.err = e; o.last = 1'b0;
      item_outs.push_back(o);
   endfunction

   function void halt(logic [2:0] e);
      emit(KIND_ERROR, '0, e);
      lex = LX_HALTED;
   endfunction

   function bit push(logic [31:0] v);
      if (depth >= StackDepth) begin
         halt(ERR_OVERFLOW);
         return 1'b0;
      end
      stk[depth] = v;
      depth++;
      return 1'b1;
   endfunction

   function bit pop(output logic [31:0] v);
      v = '0;
      if (depth == 0) begin
         halt(ERR_UNDERFLOW);
         return 1'b0;
      end
      depth--;
      v = stk[depth];
      return 1'b1;
   endfunction

   function void final_pop();
      logic [31:0] v;
      if (pop(v)) emit(KIND_RESULT, v, ERR_NONE);
      lex = LX_HALTED;
   endfunction

   // two operands off the stack, result back on
   function void arith(logic [7:0] c);
      logic [31:0] a, b, r;
      longint      sa, sb;
      bit          ok;
      if (depth < 2) begin
         halt(ERR_UNDERFLOW);
         return;
      end
      b = stk[depth-1];
      a = stk[depth-2];
      depth -= 2;
      sa = longint'(signed'(a));
      sb = longint'(signed'(b));
      r = '0;
      case (c)
         CH_PLUS:  r = a + b;
         CH_MINUS: r = a - b;
         CH_STAR:  r = a * b;
         CH_SLASH, CH_BSLASH: begin
            if (b == 0) begin
               halt(ERR_DIV_ZERO);
               return;
            end
            r = (c == CH_SLASH) ? 32'(sa / sb) : 32'(sa % sb);
         end
         CH_LESS:  r = (sa < sb) ? 32'd1 : 32'd0;
         CH_EQUAL: r = (a == b) ? 32'd1 : 32'd0;
         default:  r = (sa > sb) ? 32'd1 : 32'd0;
      endcase
      ok = push(r);
   endfunction

   function void idle_char(logic [7:0] c);
      logic [31:0] v, addr;
      bit          ok;
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         acc = 32'(c - CH_ZERO);
         lex = LX_NUMBER;
         return;
      end
      if (c >= CH_UPPA && c <= CH_UPPZ) begin
         ok = push(32'(c - CH_UPPA));
         return;
      end
      case (c)
         CH_COLON: begin
            if (depth < 2) begin
               halt(ERR_UNDERFLOW);
               return;
            end
            addr = stk[depth-1];
            v = stk[depth-2];
            depth -= 2;
            if (addr >= NumVars) halt(ERR_BAD_ADDR);
            else vars[addr] = v;
         end
         CH_DOT: begin
            if (!pop(addr)) return;
            if (addr >= NumVars) halt(ERR_BAD_ADDR);
            else ok = push(vars[addr]);
         end
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_BSLASH, CH_LESS, CH_EQUAL, CH_GREAT:
            arith(c);
         CH_TICK:   lex = LX_CHARLIT;
         CH_QMARK:  lex = LX_READ;
         CH_BANG: begin
            if (pop(v)) begin
               acc = v;
               lex = LX_PRINT;
            end
         end
         CH_QUOTE:  lex = LX_STRING;
         CH_DOLLAR: final_pop();
         default:   halt(ERR_BAD_CHAR);
      endcase
   endfunction

   // predict the results of one accepted input transaction
   function void note_input(logic mode, logic [7:0] c, logic [31:0] rv);
      logic [2:0] st;
      bit         ok;
      st = lex;
      item_outs.delete();
      if (mode) begin
         lex = LX_IDLE;
         if (st == LX_NUMBER) ok = push(acc);
         else if (st == LX_READ) ok = push(rv);
         else if (st == LX_PRINT) emit(KIND_NUM, acc, ERR_NONE);
         else if (st == LX_HALTED) lex = LX_HALTED;
         if (lex != LX_HALTED) final_pop();
         clear();
      end else begin
         case (st)
            LX_HALTED: ;
            LX_NUMBER: begin
               if (c >= CH_ZERO && c <= CH_NINE) begin
                  acc = acc * 10 + 32'(c - CH_ZERO);
               end else begin
                  lex = LX_IDLE;
                  if (push(acc)) idle_char(c);
               end
            end
            LX_CHARLIT: begin
               lex = LX_IDLE;
               ok = push(32'(c));
            end
            LX_READ: begin
               lex = LX_IDLE;
               if (c == CH_TICK) ok = push(rv);
               else if (push(rv)) idle_char(c);
            end
            LX_PRINT: begin
               lex = LX_IDLE;
               if (c == CH_TICK) begin
                  emit(KIND_CHAR, {24'd0, acc[7:0]}, ERR_NONE);
               end else begin
                  emit(KIND_NUM, acc, ERR_NONE);
                  idle_char(c);
               end
            end
            LX_STRING: begin
               if (c == CH_QUOTE) lex = LX_IDLE;
               else emit(KIND_CHAR, (c == CH_BANG) ? 32'd10 : 32'(c), ERR_NONE);
            end
            default: begin
               lex = LX_IDLE;
               idle_char(c);
            end
         endcase
      end
      if (item_outs.size() > 0) item_outs[item_outs.size()-1].last = 1'b1;
      foreach (item_outs[i]) pending_outs.push_back(item_outs[i]);
   endfunction

   function void check_result(logic [1:0] k, logic [31:0] v, logic [2:0] e, logic l);
      interp_out_type x;
      if (pending_outs.size() == 0) begin
         $error("unexpected result kind=%0d value=%0h err=%0d", k, v, e);
         failures++;
         return;
      end
      x = pending_outs.pop_front();
      if (k !== x.kind) begin
         $error("kind: expected %0d actual %0d", x.kind, k);
         failures++;
      end
      if (v !== x.value) begin
         $error("value: expected %0h actual %0h", x.value, v);
         failures++;
      end
      if (e !== x.err) begin
         $error("error_code: expected %0d actual %0d", x.err, e);
         failures++;
      end
      if (l !== x.last) begin
         $error("last: expected %0d actual %0d", x.last, l);
         failures++;
      end
   endfunction
endclass

module tb_top;
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_mode;
   logic [7:0]         req_code_char;
   logic signed [31:0] req_read_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_kind;
   logic signed [31:0] rsp_value;
   logic [2:0]         rsp_error_code;
   logic               rsp_last;

   interp_scoreboard sb;
   int idle_pct;
   int stall_pct;
   int items_sent;

   stack_language_interpreter_unit dut (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // random receiver backpressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // check each accepted result transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_kind, rsp_value, rsp_error_code, rsp_last);
   end

   function automatic logic [31:0] pick_read_value();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // drive one transaction; entered and left at a falling edge
   task automatic send(input logic mode, input logic [7:0] c);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_mode = mode;
      req_code_char = c;
      req_read_value = pick_read_value();
      do @(posedge clock); while (req_stall);
      sb.note_input(mode, c, req_read_value);
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send(1'b0, s[i]);
   endtask

   task automatic end_program();
      send(1'b1, 8'($urandom));
   endtask

   task automatic send_number(input logic [31:0] n);
      string s;
      s = $sformatf("%0d", n);
      send_text(s);
      send(1'b0, CH_SPACE);
   endtask

   task automatic send_letter();
      send(1'b0, 8'(CH_UPPA + $urandom_range(25)));
   endtask

   // one well-formed token, with occasional noise
   task automatic send_token();
      logic [7:0] ops [8];
      int         n;
      ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_BSLASH, CH_LESS, CH_EQUAL, CH_GREAT};
      if (sb.depth < 2 && $urandom_range(3) != 0) begin
         if ($urandom_range(1)) send_number($urandom_range(3) == 0 ? $urandom
                                                                   : $urandom_range(0, 99));
         else send_letter();
         return;
      end
      case ($urandom_range(15))
         0, 1:  send_number($urandom_range(0, 1000));
         2:     send_number($urandom);
         3:     send_letter();
         4: begin
            send_number($urandom_range(0, 500));
            send_letter();
            send(1'b0, CH_COLON);
         end
         5: begin
            send_letter();
            send(1'b0, CH_DOT);
         end
         6, 7, 8: send(1'b0, ops[$urandom_range(7)]);
         9: begin
            send(1'b0, CH_TICK);
            send(1'b0, 8'($urandom));
         end
         10: begin
            send(1'b0, CH_QMARK);
            if ($urandom_range(1)) send(1'b0, CH_TICK);
         end
         11: begin
            send(1'b0, CH_BANG);
            if ($urandom_range(1)) send(1'b0, CH_TICK);
         end
         12: begin
            n = $urandom_range(1, 4);
            send(1'b0, CH_QUOTE);
            repeat (n) send(1'b0, $urandom_range(1) ? CH_BANG : 8'($urandom_range(32, 126)));
            if (sb.lex == LX_STRING) send(1'b0, CH_QUOTE);
         end
         13: send(1'b0, $urandom_range(1) ? CH_SPACE : CH_LF);
         14: send(1'b0, $urandom_range(15) == 0 ? CH_DOLLAR : CH_TAB);
         default: send(1'b0, 8'($urandom));
      endcase
   endtask

   // send random programs until about the given number of transactions went out
   task automatic run_programs(input int items);
      int stop;
      stop = items_sent + items;
      while (items_sent < stop) begin
         repeat ($urandom_range(2, 14)) send_token();
         end_program();
      end
   endtask

   initial begin
      #5ms;
      $display("[stack_language_interpreter_unit] ERROR");
      $finish;
   end

   initial begin
      sb = new();
      idle_pct = 0;
      stall_pct = 0;
      items_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_code_char = '0;
      req_read_value = '0;
      rsp_stall = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: wrap, strings, char literals, reads, division corners, errors
      send_text("2147483648 1-!"); end_program();
      send_text("\"Hi!\"'z!'?'?"); end_program();
      send_text("2147483648 0 1-/$"); end_program();
      send_text("2147483648 0 1-\\"); end_program();
      send_text("5 0/"); end_program();
      send_text("7 0\\"); end_program();
      send_text("9Z:Z.26."); end_program();
      send_text("1 26:"); end_program();
      send_text("3 4<3 4=3 4>+!"); end_program();
      send_text("4294967295 99999999999"); end_program();
      send_text("+"); end_program();
      send_text("!"); end_program();
      send(1'b0, 8'h00); end_program();
      send(1'b0, 8'hff); end_program();
      send_text("a"); end_program();
      send_text("1$ junk"); end_program();
      send_text("?"); end_program();
      end_program();

      // random phases with different idling mixes
      idle_pct = 0;  stall_pct = 0;  run_programs(250);
      idle_pct = 80; stall_pct = 0;  run_programs(250);
      idle_pct = 0;  stall_pct = 80; run_programs(250);
      idle_pct = 11; stall_pct = 11; run_programs(250);

      while (sb.pending_outs.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (sb.failures == 0 && sb.pending_outs.size() == 0)
         $display("[stack_language_interpreter_unit] OK");
      else
         $display("[stack_language_interpreter_unit] ERROR");
      $finish;
   end
endmodule
